@@ rtl/vrt_pkg.sv @@
// Package for the voxel ray walker: shared constants, result kinds and FSM states.
// Used by every module under rtl; depends on nothing.
package vrt_pkg;

    localparam int IN_COORD_W = 32;
    localparam int TIME_W = 32;
    localparam int DEF_COORD_INT_BITS = 24;
    localparam int DEF_COORD_FRAC_BITS = 8;
    localparam int DEF_TIME_FRAC_BITS = 16;

    typedef enum logic [1:0] {
        KIND_QUERY = 2'd0,
        KIND_HIT   = 2'd1,
        KIND_MISS  = 2'd2
    } kind_t;

    typedef enum logic [0:0] {
        REQ_START  = 1'b0,
        REQ_ANSWER = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SETUP = 2'd1,
        ST_DIV   = 2'd2
    } state_t;

    typedef struct packed {
        logic div_start;
        logic axis_init;
        logic div_write;
        logic inf_write;
        logic advance;
        logic emit_query;
        logic answer;
    } ctl_t;

endpackage

@@ rtl/vrt_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle, 32-bit saturated quotient.
// Depends on vrt_pkg.
module vrt_div #(
    parameter int NUM_W = 25
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [NUM_W-1:0]           num,
    input  logic [32:0]                den,
    output logic                       done,
    output logic [vrt_pkg::TIME_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  n_reg, n_next;
    logic [NUM_W-1:0]  q_reg, q_next;
    logic [32:0]       rem_reg, rem_next;
    logic [32:0]       den_reg, den_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [33:0]       shifted;
    logic [34:0]       diff;
    logic [NUM_W+31:0] q_ext;

    assign shifted = {rem_reg, n_reg[NUM_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};
    assign q_ext   = {32'd0, q_reg};

    always_comb
    begin
        n_next    = n_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            n_next    = num;
            q_next    = '0;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[34])
                rem_next = diff[32:0];
            else
                rem_next = shifted[32:0];
            q_next   = {q_reg[NUM_W-2:0], ~diff[34]};
            n_next   = {n_reg[NUM_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = (q_ext[NUM_W+31:32] != '0) ? '1 : q_ext[31:0];

endmodule

@@ rtl/vrt_step.sv @@
// One walk step: picks the axis with least t_next, saturating advance, entry time, end check.
// Depends on vrt_pkg.
module vrt_step #(
    parameter int TIME_FRAC_BITS = vrt_pkg::DEF_TIME_FRAC_BITS
) (
    input  logic [2:0][vrt_pkg::TIME_W-1:0] t_next,
    input  logic [2:0][vrt_pkg::TIME_W-1:0] t_step,
    output logic [1:0]                      axis,
    output logic [vrt_pkg::TIME_W-1:0]      t_new,
    output logic [TIME_FRAC_BITS:0]         entry,
    output logic                            done
);

    localparam logic [vrt_pkg::TIME_W-1:0] T_ONE = vrt_pkg::TIME_W'(1) << TIME_FRAC_BITS;

    logic [vrt_pkg::TIME_W:0]   sum;
    logic [vrt_pkg::TIME_W-1:0] t_sel;
    logic [2:0]                 beyond;

    always_comb
    begin
        if (t_next[0] < t_next[1])
            axis = (t_next[0] < t_next[2]) ? 2'd0 : 2'd2;
        else
            axis = (t_next[1] < t_next[2]) ? 2'd1 : 2'd2;
        t_sel = t_next[axis];
        sum   = {1'b0, t_sel} + {1'b0, t_step[axis]};
        t_new = sum[vrt_pkg::TIME_W] ? '1 : sum[vrt_pkg::TIME_W-1:0];
        entry = (t_sel > T_ONE) ? T_ONE[TIME_FRAC_BITS:0] : t_sel[TIME_FRAC_BITS:0];
        for (int a = 0; a < 3; a++)
            beyond[a] = ((a == int'(axis)) ? t_new : t_next[a]) > T_ONE;
        done = &beyond;
    end

endmodule

@@ rtl/voxel_ray_traversal.sv @@
// Top level of the voxel ray walker: stream ports, control FSM, walk state, output register.
// Depends on vrt_pkg, vrt_div and vrt_step.
//
// Input stream s_*: tuser[0] is the request type (start a ray or answer the last query).
// A start transfer carries both ray end points; an answer carries loaded/occupied flags.
// Output stream m_*: tuser holds the result kind (query, hit or miss); tdata the voxel,
// hit time and entry normal. Every start gives one query; every answer during a walk gives
// a query, a hit or a miss; an answer with no walk running gives nothing.
// Setup: a start runs six serial divisions (step and next time per axis) in the shared
// divider; an axis with zero span skips its divisions. An answer is resolved
// combinationally, and its result shows in the output register on the next cycle.
// One item at a time: s_tready is high only with no walk setup under way and the output
// register empty, so a receiver stall on m_* holds the result and blocks new input.
// Reset clears the walk, empties the output register and sets all times to infinity.
module voxel_ray_traversal #(
    parameter int COORD_INT_BITS  = vrt_pkg::DEF_COORD_INT_BITS,
    parameter int COORD_FRAC_BITS = vrt_pkg::DEF_COORD_FRAC_BITS,
    parameter int TIME_FRAC_BITS  = vrt_pkg::DEF_TIME_FRAC_BITS,
    localparam int S_DATA_W = 200,
    localparam int M_RAW_W  = 3 * COORD_INT_BITS + TIME_FRAC_BITS + 8,
    localparam int M_DATA_W = ((M_RAW_W + 7) / 8) * 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, voxel_loaded, voxel_occupied
    input  logic [S_DATA_W-1:0] s_tdata,
    // req_type
    input  logic [0:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // voxel_x, voxel_y, voxel_z, hit_time, normal_valid, normal_x, normal_y, normal_z
    output logic [M_DATA_W-1:0] m_tdata,
    // result_kind
    output logic [1:0]          m_tuser
);

    localparam int CW    = vrt_pkg::IN_COORD_W;
    localparam int IW    = COORD_INT_BITS;
    localparam int TW    = vrt_pkg::TIME_W;
    localparam int HW    = TIME_FRAC_BITS + 1;
    localparam int NUM_W = COORD_FRAC_BITS + TIME_FRAC_BITS + 1;

    vrt_pkg::state_t state_reg, state_next;
    vrt_pkg::ctl_t   ctl;

    logic [1:0]              ax_reg, ax_next;
    logic                    phase_reg, phase_next;
    logic [2:0][CW-1:0]      start_reg, start_next;
    logic [2:0][CW-1:0]      end_reg, end_next;
    logic                    active_reg, active_next;
    logic [2:0][IW-1:0]      cur_reg, cur_next;
    logic [2:0][IW-1:0]      prev_reg, prev_next;
    logic [2:0][IW-1:0]      origin_reg, origin_next;
    logic [2:0][1:0]         step_reg, step_next;
    logic [2:0][TW-1:0]      tn_reg, tn_next;
    logic [2:0][TW-1:0]      ts_reg, ts_next;
    logic [HW-1:0]           entry_reg, entry_next;

    logic                    ovalid_reg, ovalid_next;
    vrt_pkg::kind_t          okind_reg, okind_next;
    logic [2:0][IW-1:0]      ovox_reg, ovox_next;
    logic [HW-1:0]           otime_reg, otime_next;
    logic                    onv_reg, onv_next;
    logic [2:0][1:0]         onrm_reg, onrm_next;

    logic                    in_xfer;
    logic                    is_start;
    logic                    ans_loaded;
    logic                    ans_occupied;
    logic [CW-1:0]           s_sel;
    logic [CW-1:0]           e_sel;
    logic [CW:0]             d;
    logic                    d_zero;
    logic [CW:0]             mag;
    logic [COORD_FRAC_BITS:0] frac;
    logic [COORD_FRAC_BITS:0] bound_gap;
    logic [NUM_W-1:0]        num;
    logic [CW-1:0]           floor_s;
    logic                    div_done;
    logic [TW-1:0]           div_quo;
    logic [1:0]              st_axis;
    logic [TW-1:0]           st_tnew;
    logic [HW-1:0]           st_entry;
    logic                    st_done;
    logic                    at_origin;
    logic [1:0]              nrm_a;

    assign s_tready     = (state_reg == vrt_pkg::ST_IDLE) && !ovalid_reg;
    assign in_xfer      = s_tvalid && s_tready;
    assign is_start     = (s_tuser[0] == vrt_pkg::REQ_START);
    assign ans_loaded   = s_tdata[6*CW];
    assign ans_occupied = s_tdata[6*CW+1];

    assign s_sel     = start_reg[ax_reg];
    assign e_sel     = end_reg[ax_reg];
    assign d         = {e_sel[CW-1], e_sel} - {s_sel[CW-1], s_sel};
    assign d_zero    = (d == '0);
    assign mag       = d[CW] ? -d : d;
    assign frac      = {1'b0, s_sel[COORD_FRAC_BITS-1:0]};
    assign bound_gap = d[CW] ? frac : ((COORD_FRAC_BITS+1)'(1) << COORD_FRAC_BITS) - frac;
    assign num       = phase_reg ? {bound_gap, TIME_FRAC_BITS'(0)}
                                 : (NUM_W'(1) << (COORD_FRAC_BITS + TIME_FRAC_BITS));
    assign floor_s   = CW'($signed(s_sel) >>> COORD_FRAC_BITS);

    vrt_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.div_start),
        .num   (num),
        .den   (mag),
        .done  (div_done),
        .quo   (div_quo)
    );

    vrt_step #(
        .TIME_FRAC_BITS (TIME_FRAC_BITS)
    ) u_step (
        .t_next (tn_reg),
        .t_step (ts_reg),
        .axis   (st_axis),
        .t_new  (st_tnew),
        .entry  (st_entry),
        .done   (st_done)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vrt_pkg::ST_IDLE:
            begin
                if (in_xfer && is_start)
                    state_next = vrt_pkg::ST_SETUP;
            end
            vrt_pkg::ST_SETUP:
            begin
                if (!d_zero)
                    state_next = vrt_pkg::ST_DIV;
                else if (ax_reg == 2'd2)
                    state_next = vrt_pkg::ST_IDLE;
            end
            vrt_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    if (!phase_reg || ax_reg != 2'd2)
                        state_next = vrt_pkg::ST_SETUP;
                    else
                        state_next = vrt_pkg::ST_IDLE;
                end
            end
            default:
                state_next = vrt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        case (state_reg)
            vrt_pkg::ST_IDLE:
                ctl.answer = in_xfer && !is_start && active_reg;
            vrt_pkg::ST_SETUP:
            begin
                ctl.axis_init  = !phase_reg;
                ctl.div_start  = !d_zero;
                ctl.inf_write  = d_zero;
                ctl.advance    = d_zero;
                ctl.emit_query = d_zero && ax_reg == 2'd2;
            end
            vrt_pkg::ST_DIV:
            begin
                ctl.div_write  = div_done;
                ctl.advance    = div_done && phase_reg;
                ctl.emit_query = div_done && phase_reg && ax_reg == 2'd2;
            end
            default:
                ctl = '0;
        endcase
    end

    always_comb
    begin
        ax_next     = ax_reg;
        phase_next  = phase_reg;
        start_next  = start_reg;
        end_next    = end_reg;
        active_next = active_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        origin_next = origin_reg;
        step_next   = step_reg;
        tn_next     = tn_reg;
        ts_next     = ts_reg;
        entry_next  = entry_reg;
        ovalid_next = ovalid_reg && !m_tready;
        okind_next  = okind_reg;
        ovox_next   = ovox_reg;
        otime_next  = otime_reg;
        onv_next    = onv_reg;
        onrm_next   = onrm_reg;
        at_origin   = (cur_reg == origin_reg);
        nrm_a       = '0;

        if (in_xfer && is_start)
        begin
            for (int a = 0; a < 3; a++)
            begin
                start_next[a] = s_tdata[a*CW +: CW];
                end_next[a]   = s_tdata[(a+3)*CW +: CW];
            end
            ax_next     = 2'd0;
            phase_next  = 1'b0;
            active_next = 1'b0;
        end

        if (ctl.axis_init)
        begin
            origin_next[ax_reg] = floor_s[IW-1:0];
            cur_next[ax_reg]    = floor_s[IW-1:0];
            prev_next[ax_reg]   = floor_s[IW-1:0];
            step_next[ax_reg]   = d_zero ? 2'b00 : (d[CW] ? 2'b11 : 2'b01);
        end
        if (ctl.inf_write)
        begin
            tn_next[ax_reg] = '1;
            ts_next[ax_reg] = '1;
        end
        if (ctl.div_write)
        begin
            if (phase_reg)
                tn_next[ax_reg] = div_quo;
            else
                ts_next[ax_reg] = div_quo;
            phase_next = 1'b1;
        end
        if (ctl.advance)
        begin
            ax_next    = ax_reg + 2'd1;
            phase_next = 1'b0;
        end
        if (ctl.emit_query)
        begin
            entry_next  = '0;
            active_next = 1'b1;
            ovalid_next = 1'b1;
            okind_next  = vrt_pkg::KIND_QUERY;
            ovox_next   = cur_next;
            otime_next  = '0;
            onv_next    = 1'b0;
            onrm_next   = '0;
        end

        if (ctl.answer)
        begin
            ovalid_next = 1'b1;
            ovox_next   = '0;
            otime_next  = '0;
            onv_next    = 1'b0;
            onrm_next   = '0;
            if (!ans_loaded)
            begin
                active_next = 1'b0;
                okind_next  = vrt_pkg::KIND_MISS;
            end
            else if (ans_occupied)
            begin
                active_next = 1'b0;
                okind_next  = vrt_pkg::KIND_HIT;
                ovox_next   = cur_reg;
                if (!at_origin)
                begin
                    otime_next = entry_reg;
                    onv_next   = 1'b1;
                    for (int a = 0; a < 3; a++)
                        onrm_next[a] = prev_reg[a][1:0] - cur_reg[a][1:0];
                end
            end
            else
            begin
                prev_next          = cur_reg;
                entry_next         = st_entry;
                nrm_a              = step_reg[st_axis];
                cur_next[st_axis]  = cur_reg[st_axis] + {{(IW-2){nrm_a[1]}}, nrm_a};
                tn_next[st_axis]   = st_tnew;
                if (st_done)
                begin
                    active_next = 1'b0;
                    okind_next  = vrt_pkg::KIND_MISS;
                end
                else
                begin
                    okind_next = vrt_pkg::KIND_QUERY;
                    ovox_next  = cur_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= vrt_pkg::ST_IDLE;
            ax_reg     <= '0;
            phase_reg  <= 1'b0;
            active_reg <= 1'b0;
            cur_reg    <= '0;
            prev_reg   <= '0;
            origin_reg <= '0;
            step_reg   <= '0;
            tn_reg     <= '1;
            ts_reg     <= '1;
            entry_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ax_reg     <= ax_next;
            phase_reg  <= phase_next;
            active_reg <= active_next;
            cur_reg    <= cur_next;
            prev_reg   <= prev_next;
            origin_reg <= origin_next;
            step_reg   <= step_next;
            tn_reg     <= tn_next;
            ts_reg     <= ts_next;
            entry_reg  <= entry_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        end_reg   <= end_next;
        okind_reg <= okind_next;
        ovox_reg  <= ovox_next;
        otime_reg <= otime_next;
        onv_reg   <= onv_next;
        onrm_reg  <= onrm_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tuser  = okind_reg;
    assign m_tdata  = M_DATA_W'({onrm_reg[2], onrm_reg[1], onrm_reg[0], onv_reg, otime_reg,
                                 ovox_reg[2], ovox_reg[1], ovox_reg[0]});

endmodule

@@ rtl/vrt_checker.sv @@
// Port-level checks for the voxel ray walker, bound to the top level.
// Depends on vrt_pkg and voxel_ray_traversal.
module vrt_checker #(
    parameter int DATA_W = 96,
    parameter int IW     = vrt_pkg::DEF_COORD_INT_BITS
) (
    input logic              clk,
    input logic              rst_n,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic [1:0]        m_tuser
);

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == vrt_pkg::KIND_MISS |-> m_tdata == '0)
        else $error("miss carries data");

    a_query_plain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == vrt_pkg::KIND_QUERY |-> m_tdata[DATA_W-1:3*IW] == '0)
        else $error("query carries time or normal");

endmodule

bind voxel_ray_traversal vrt_checker #(
    .DATA_W (M_DATA_W),
    .IW     (COORD_INT_BITS)
) u_vrt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
